/* hw/rtl/nv12tp_pkg.sv */
// Shared types, constants and helper functions of the NV12 test-pattern block generator.
`default_nettype none

package nv12tp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLineStride   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgChromaStep   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPatternOffs  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgFixedColor   = 3'd5;

  localparam int unsigned DimW    = 13;
  localparam int unsigned StepW   = 3;
  localparam int unsigned POffW   = 16;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned SumW    = 17;
  localparam int unsigned OffsW   = 24;
  localparam int unsigned SampleW = 8;

  localparam logic [DimW-1:0]  DimRst        = 13'd1024;
  localparam logic [StepW-1:0] ChromaStepRst = 3'd2;

  localparam int unsigned DivBitsPerStg = 3;
  localparam int unsigned DivStages     = 6;
  localparam int unsigned QuoW          = DivBitsPerStg * DivStages;

  localparam int unsigned StgOffs    = 3;
  localparam int unsigned StgPat     = DivStages + 1;
  localparam int unsigned StgRgb     = DivStages + 2;
  localparam int unsigned StgLumaMul = DivStages + 3;
  localparam int unsigned StgLuma    = DivStages + 4;
  localparam int unsigned StgChrMul  = DivStages + 5;
  localparam int unsigned StgOut     = DivStages + 6;
  localparam int unsigned PipeStages = DivStages + 7;

  localparam logic [ColorW-1:0] PatQMul = 24'h130502;
  localparam logic [ColorW-1:0] PatRMul = 24'h0a1120;

  localparam logic [ColorW-1:0] LumaKr = 24'd19595;
  localparam logic [ColorW-1:0] LumaKg = 24'd38470;
  localparam logic [ColorW-1:0] LumaKb = 24'd7471;

  localparam logic signed [25:0] CbK     = 26'sd37028;
  localparam logic signed [25:0] CrK     = 26'sd46727;
  localparam logic signed [25:0] ChrBias = 26'sd8388608;

  typedef struct packed {
    logic [SumW-1:0] s;
    logic [QuoW-1:0] dvd;
    logic [QuoW-1:0] quo;
    logic [DimW-1:0] rem;
  } div_t;

  typedef struct packed {
    logic [OffsW-1:0] luma_off;
    logic [OffsW-1:0] chroma_off;
    logic             last;
  } side_t;

  function automatic div_t div_step(div_t a, logic [DimW-1:0] w);
    div_t          r;
    logic [DimW:0] part;
    r = a;
    for (int i = 0; i < DivBitsPerStg; i++) begin
      part  = {r.rem, r.dvd[QuoW-1]};
      r.dvd = {r.dvd[QuoW-2:0], 1'b0};
      if (part >= {1'b0, w}) begin
        part  = part - {1'b0, w};
        r.quo = {r.quo[QuoW-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QuoW-2:0], 1'b0};
      end
      r.rem = part[DimW-1:0];
    end
    return r;
  endfunction

  function automatic logic [SampleW-1:0] chroma_sat(logic signed [25:0] t);
    logic [SampleW-1:0] res;
    if (t[25]) begin
      res = '0;
    end else if (t[24]) begin
      res = '1;
    end else begin
      res = t[23:16];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/nv12_test_pattern_block_top.sv */
// Top level of the NV12 test-pattern block generator: pattern, color conversion and offsets.
//
//   channel  direction  handshake                payload
//   cfg      in         cfg_we_i                 cfg_idx_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o  block_x_i, block_y_i
//   out      out        out_valid_o / out_stall_i luma/cb/cr values, offsets, last_block
//
// One block per clock while no stall holds the pipeline; 13 register stages lie between
// an input transfer and its result.
// The pattern quotient runs through a six-stage divider, three quotient bits per stage.
// Reset clears the valid bits and loads the register defaults.
// A stage holds only while the output is stalled and it and all later stages are full;
// empty stages close up, so input is taken while a result waits and a stage is free.
`default_nettype none

module nv12_test_pattern_block_top
  import nv12tp_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CoordW-1:0]   block_x_i,
  input  wire logic [CoordW-1:0]   block_y_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SampleW-1:0]       luma_value_o,
  output logic [SampleW-1:0]       cb_value_o,
  output logic [SampleW-1:0]       cr_value_o,
  output logic [OffsW-1:0]         luma_offset_o,
  output logic [OffsW-1:0]         chroma_offset_o,
  output logic                     last_block_o
);

  localparam int unsigned        DimCmpW = DimW + 2;
  localparam logic [DimCmpW-1:0] MaxDimV = DimCmpW'(MAX_DIM);

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    return ({2'b00, v} > MaxDimV) ? MaxDimV[DimW-1:0] : v;
  endfunction

  logic [DimW-1:0]   width_q, height_q, stride_q;
  logic [StepW-1:0]  cstep_q;
  logic [POffW-1:0]  poff_q;
  logic [ColorW-1:0] fixed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimRst;
      height_q <= DimRst;
      stride_q <= DimRst;
      cstep_q  <= ChromaStepRst;
      poff_q   <= '0;
      fixed_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFrameWidth:  width_q  <= cfg_data_i[DimW-1:0];
        CfgFrameHeight: height_q <= cfg_data_i[DimW-1:0];
        CfgLineStride:  stride_q <= cfg_data_i[DimW-1:0];
        CfgChromaStep:  cstep_q  <= cfg_data_i[StepW-1:0];
        CfgPatternOffs: poff_q   <= cfg_data_i[POffW-1:0];
        CfgFixedColor:  fixed_q  <= cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  logic [DimW-1:0] w_c, h_c, stride_c;
  logic            wzero_c;

  assign w_c      = clamp_dim(width_q);
  assign h_c      = clamp_dim(height_q);
  assign stride_c = clamp_dim(stride_q);
  assign wzero_c  = (w_c == '0);

  logic [PipeStages-1:0] v_q, en;

  for (genvar k = 0; k < PipeStages; k++) begin : g_en
    assign en[k] = !out_stall_i || !(&v_q[PipeStages-1:k]);
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[PipeStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PipeStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  logic [CoordW-1:0]  bx0_q, by0_q;
  logic [SumW-1:0]    s0_q;
  div_t               div_q [1:DivStages];
  div_t               div_init_d;

  logic [24:0]        lo_prod1_q;
  logic [23:0]        cp1_q;
  logic [CoordW-1:0]  bx1_q;
  logic               last1_q;
  logic               last1_d;

  logic [OffsW-1:0]   luma_off2_q;
  logic [24:0]        cp2_q;
  logic [13:0]        cx2_q;
  logic               last2_q;

  side_t              side_q [StgOffs:PipeStages-1];

  logic [11:0]        qsh_d;
  logic [10:0]        rsh_d;
  logic [ColorW-1:0]  pq_q, pr_q, rgb_q;
  logic [ColorW-1:0]  yr_q, yg_q, yb_q;
  logic [SampleW-1:0] rch_q, bch_q;
  logic [24:0]        ysum_d;
  logic [SampleW-1:0] luma10_q, r10_q, b10_q;
  logic signed [8:0]  db_d, dr_d;
  logic signed [25:0] tb_q, tr_q;
  logic [SampleW-1:0] luma11_q;
  logic [SampleW-1:0] luma_out_q, cb_out_q, cr_out_q;

  always_comb begin
    div_init_d     = '0;
    div_init_d.s   = s0_q;
    div_init_d.dvd = QuoW'(s0_q);
    last1_d = ((DimW'(bx0_q) + DimW'(2)) >= w_c) && ((DimW'(by0_q) + DimW'(2)) >= h_c);
    qsh_d   = wzero_c ? '0 : div_q[DivStages].quo[QuoW-1:6];
    rsh_d   = wzero_c ? div_q[DivStages].s[SumW-1:6] : 11'(div_q[DivStages].rem[DimW-1:6]);
    ysum_d  = 25'(yr_q) + 25'(yg_q) + 25'(yb_q);
    db_d    = $signed({1'b0, b10_q}) - $signed({1'b0, luma10_q});
    dr_d    = $signed({1'b0, r10_q}) - $signed({1'b0, luma10_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      bx0_q <= block_x_i;
      by0_q <= block_y_i;
      s0_q  <= SumW'(poff_q) + SumW'(block_x_i) + SumW'(block_y_i);
    end
    if (en[1]) begin
      div_q[1]   <= div_step(div_init_d, w_c);
      lo_prod1_q <= 25'(by0_q) * 25'(stride_c);
      cp1_q      <= 24'(by0_q[CoordW-1:1]) * 24'(stride_c);
      bx1_q      <= bx0_q;
      last1_q    <= last1_d;
    end
    for (int k = 2; k <= DivStages; k++) begin
      if (en[k]) begin
        div_q[k] <= div_step(div_q[k-1], w_c);
      end
    end
    if (en[2]) begin
      luma_off2_q <= OffsW'(lo_prod1_q) + OffsW'(bx1_q);
      cp2_q       <= 25'(cp1_q) * 25'(cstep_q);
      cx2_q       <= 14'(bx1_q[CoordW-1:1]) * 14'(cstep_q);
      last2_q     <= last1_q;
    end
    if (en[StgOffs]) begin
      side_q[StgOffs].luma_off   <= luma_off2_q;
      side_q[StgOffs].chroma_off <= cp2_q[24:1] + OffsW'(cx2_q);
      side_q[StgOffs].last       <= last2_q;
    end
    for (int k = StgOffs + 1; k < PipeStages; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
    if (en[StgPat]) begin
      pq_q <= ColorW'(qsh_d) * PatQMul;
      pr_q <= ColorW'(rsh_d) * PatRMul;
    end
    if (en[StgRgb]) begin
      rgb_q <= (fixed_q != '0) ? fixed_q : pq_q + pr_q;
    end
    if (en[StgLumaMul]) begin
      yr_q  <= ColorW'(rgb_q[23:16]) * LumaKr;
      yg_q  <= ColorW'(rgb_q[15:8]) * LumaKg;
      yb_q  <= ColorW'(rgb_q[7:0]) * LumaKb;
      rch_q <= rgb_q[23:16];
      bch_q <= rgb_q[7:0];
    end
    if (en[StgLuma]) begin
      luma10_q <= ysum_d[23:16];
      r10_q    <= rch_q;
      b10_q    <= bch_q;
    end
    if (en[StgChrMul]) begin
      tb_q     <= 26'(db_d) * CbK + ChrBias;
      tr_q     <= 26'(dr_d) * CrK + ChrBias;
      luma11_q <= luma10_q;
    end
    if (en[StgOut]) begin
      luma_out_q <= luma11_q;
      cb_out_q   <= chroma_sat(tb_q);
      cr_out_q   <= chroma_sat(tr_q);
    end
  end

  assign luma_value_o    = luma_out_q;
  assign cb_value_o      = cb_out_q;
  assign cr_value_o      = cr_out_q;
  assign luma_offset_o   = side_q[PipeStages-1].luma_off;
  assign chroma_offset_o = side_q[PipeStages-1].chroma_off;
  assign last_block_o    = side_q[PipeStages-1].last;

endmodule

`default_nettype wire

/* hw/rtl/nv12tp_checker.sv */
// Port-level checker for the NV12 test-pattern block generator, bound to its top level.
`default_nettype none

module nv12tp_checker
  import nv12tp_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [SampleW-1:0]  luma_value_o,
  input wire logic [SampleW-1:0]  cb_value_o,
  input wire logic [SampleW-1:0]  cr_value_o,
  input wire logic [OffsW-1:0]    luma_offset_o,
  input wire logic [OffsW-1:0]    chroma_offset_o,
  input wire logic                last_block_o
);

  localparam int unsigned CntW = $clog2(PipeStages + 2);

  logic            in_xfer, out_xfer;
  logic [CntW-1:0] inflight_q, inflight_d;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign inflight_d = inflight_q + CntW'(in_xfer) - CntW'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("result shown with no item in flight");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(PipeStages))
    else $error("more items in flight than pipeline stages");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(luma_value_o)
      && $stable(cb_value_o) && $stable(cr_value_o) && $stable(luma_offset_o)
      && $stable(chroma_offset_o) && $stable(last_block_o))
    else $error("stalled result changed");

endmodule

bind nv12_test_pattern_block_top nv12tp_checker u_checker (.*);

`default_nettype wire

/* dv/tb_nv12_test_pattern_block_top.sv */
// Self-checking testbench of the NV12 test-pattern block generator top level.
`timescale 1ns / 1ps

module tb_nv12_test_pattern_block_top;
  import nv12tp_pkg::*;

  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned NumPhases = 10;
  localparam int unsigned PhaseLen  = 70;
  localparam int unsigned LongHold  = 60;
  localparam int unsigned EndWait   = 20;
  localparam int unsigned CycLimit  = 400000;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct packed {
    logic [SampleW-1:0] luma_value;
    logic [SampleW-1:0] cb_value;
    logic [SampleW-1:0] cr_value;
    logic [OffsW-1:0]   luma_offset;
    logic [OffsW-1:0]   chroma_offset;
    logic               last_block;
  } blk_res_t;

  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    bit                  typed;
    blk_res_t            res;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CoordW-1:0]   block_x_i;
  logic [CoordW-1:0]   block_y_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [SampleW-1:0]  luma_value_o;
  logic [SampleW-1:0]  cb_value_o;
  logic [SampleW-1:0]  cr_value_o;
  logic [OffsW-1:0]    luma_offset_o;
  logic [OffsW-1:0]    chroma_offset_o;
  logic                last_block_o;

  logic [DimW-1:0]   reg_width;
  logic [DimW-1:0]   reg_height;
  logic [DimW-1:0]   reg_stride;
  logic [StepW-1:0]  reg_step;
  logic [POffW-1:0]  reg_offset;
  logic [ColorW-1:0] reg_fixed;

  blk_res_t    nv12_block_q[$];
  stim_row_t   dir_rows[$];
  blk_res_t    typed_res;
  bit          typed_armed   = 1'b0;
  bit          in_take       = 1'b0;
  bit          valid_up      = 1'b0;
  bit          tx_idle_en    = 1'b0;
  bit          rx_idle_en    = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned err_cnt       = 0;
  int unsigned n_in          = 0;
  int unsigned n_out         = 0;
  int unsigned n_cfg         = 0;
  int unsigned n_last        = 0;
  int unsigned cyc           = 0;

  nv12_test_pattern_block_top #(
    .MAX_DIM(MaxDim)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .block_x_i      (block_x_i),
    .block_y_i      (block_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .luma_value_o   (luma_value_o),
    .cb_value_o     (cb_value_o),
    .cr_value_o     (cr_value_o),
    .luma_offset_o  (luma_offset_o),
    .chroma_offset_o(chroma_offset_o),
    .last_block_o   (last_block_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycLimit) begin
      $display("tb_nv12_test_pattern_block_top: FAIL");
      $finish;
    end
  end

  function automatic longint unsigned dim_clamp(input logic [DimW-1:0] v);
    longint unsigned d;
    d = v;
    if (d > MaxDim) begin
      d = MaxDim;
    end
    return d;
  endfunction

  function automatic logic [SampleW-1:0] chroma_calc(input longint c, input longint ly,
                                                     input longint k);
    longint             t;
    logic [SampleW-1:0] res;
    t = (c - ly) * k + 128 * 65536;
    if (t < 0) begin
      res = '0;
    end else if ((t >>> 16) > 255) begin
      res = '1;
    end else begin
      res = t[23:16];
    end
    return res;
  endfunction

  function automatic blk_res_t nv12_block_calc(input logic [CoordW-1:0] bx_in,
                                               input logic [CoordW-1:0] by_in);
    longint unsigned w, h, st, stp, bx, by, s, q, r, rgb, loff, coff;
    longint          rd, gr, bl, ly;
    blk_res_t        res;
    bx  = bx_in;
    by  = by_in;
    w   = dim_clamp(reg_width);
    h   = dim_clamp(reg_height);
    st  = dim_clamp(reg_stride);
    stp = reg_step;
    s   = longint'(reg_offset) + bx + by;
    if (w == 0) begin
      q = 0;
      r = s;
    end else begin
      q = s / w;
      r = s % w;
    end
    rgb = (64'h130502 * (q >> 6) + 64'h0a1120 * (r >> 6)) & 64'hFFFF_FFFF;
    if (reg_fixed != 0) begin
      rgb = reg_fixed;
    end
    rd = (rgb >> 16) & 255;
    gr = (rgb >> 8) & 255;
    bl = rgb & 255;
    ly = (19595 * rd + 38470 * gr + 7471 * bl) >>> 16;
    loff = by * st + bx;
    coff = (((by >> 1) * st * stp) >> 1) + (bx >> 1) * stp;
    res.luma_value    = ly[7:0];
    res.cb_value      = chroma_calc(bl, ly, 37028);
    res.cr_value      = chroma_calc(rd, ly, 46727);
    res.luma_offset   = loff[23:0];
    res.chroma_offset = coff[23:0];
    res.last_block    = (bx + 2 >= w) && (by + 2 >= h);
    return res;
  endfunction

  always @(negedge clk_i) begin : monitor
    blk_res_t got;
    blk_res_t want;
    in_take = rst_ni && in_valid_i && !in_stall_o;
    if (in_take) begin
      if (typed_armed) begin
        nv12_block_q.push_back(typed_res);
        typed_armed = 1'b0;
      end else begin
        nv12_block_q.push_back(nv12_block_calc(block_x_i, block_y_i));
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.luma_value    = luma_value_o;
      got.cb_value      = cb_value_o;
      got.cr_value      = cr_value_o;
      got.luma_offset   = luma_offset_o;
      got.chroma_offset = chroma_offset_o;
      got.last_block    = last_block_o;
      n_out++;
      if (last_block_o === 1'b1) begin
        n_last++;
      end
      if (nv12_block_q.size() == 0) begin
        $error("unexpected result transfer, luma_offset %0h", luma_offset_o);
        err_cnt++;
      end else begin
        want = nv12_block_q.pop_front();
        if (got.luma_value !== want.luma_value) begin
          $error("luma_value expected %0d actual %0d", want.luma_value, got.luma_value);
          err_cnt++;
        end
        if (got.cb_value !== want.cb_value) begin
          $error("cb_value expected %0d actual %0d", want.cb_value, got.cb_value);
          err_cnt++;
        end
        if (got.cr_value !== want.cr_value) begin
          $error("cr_value expected %0d actual %0d", want.cr_value, got.cr_value);
          err_cnt++;
        end
        if (got.luma_offset !== want.luma_offset) begin
          $error("luma_offset expected %0h actual %0h", want.luma_offset, got.luma_offset);
          err_cnt++;
        end
        if (got.chroma_offset !== want.chroma_offset) begin
          $error("chroma_offset expected %0h actual %0h", want.chroma_offset,
                 got.chroma_offset);
          err_cnt++;
        end
        if (got.last_block !== want.last_block) begin
          $error("last_block expected %0d actual %0d", want.last_block, got.last_block);
          err_cnt++;
        end
      end
    end
  end

  initial begin : rx_side
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgFrameWidth:  reg_width  = val[DimW-1:0];
      CfgFrameHeight: reg_height = val[DimW-1:0];
      CfgLineStride:  reg_stride = val[DimW-1:0];
      CfgChromaStep:  reg_step   = val[StepW-1:0];
      CfgPatternOffs: reg_offset = val[POffW-1:0];
      CfgFixedColor:  reg_fixed  = val[ColorW-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic send_block(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    int unsigned n;
    block_x_i  <= x;
    block_y_i  <= y;
    in_valid_i <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk_i); while (!in_take);
    n_in++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    while (nv12_block_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    dir_rows.push_back(row);
  endtask

  task automatic add_item(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    stim_row_t row;
    row   = '{default: '0};
    row.x = x;
    row.y = y;
    dir_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                           input blk_res_t res);
    stim_row_t row;
    row       = '{default: '0};
    row.x     = x;
    row.y     = y;
    row.typed = 1'b1;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  function automatic logic [CfgDataW-1:0] pick_dim();
    logic [CfgDataW-1:0] d;
    int unsigned         v;
    case ($urandom_range(0, 6))
      0:       v = 2;
      1:       v = MaxDim;
      2:       v = $urandom_range(2, 64);
      3:       v = $urandom_range(2, MaxDim);
      4:       v = $urandom_range(MaxDim + 1, 8191);
      5:       v = $urandom_range(0, 1);
      default: v = $urandom_range(2, 512);
    endcase
    d          = CfgDataW'($urandom);
    d[DimW-1:0] = v[DimW-1:0];
    return d;
  endfunction

  function automatic logic [CoordW-1:0] rand_coord(input logic [DimW-1:0] dim);
    longint unsigned lim;
    int unsigned     t;
    int unsigned     k;
    lim = dim_clamp(dim);
    lim = (lim >= 2) ? lim - 2 : 0;
    if (lim > 4094) begin
      lim = 4094;
    end
    k = $urandom_range(0, 9);
    if (k < 6) begin
      t = $urandom_range(0, int'(lim / 2)) * 2;
    end else if (k < 8) begin
      t = int'(lim);
      if (t >= 2 && $urandom_range(0, 1) == 1) begin
        t = t - 2;
      end
    end else begin
      t = $urandom;
    end
    return t[CoordW-1:0];
  endfunction

  task automatic config_phase(input int unsigned phase);
    logic [CfgDataW-1:0] v;
    if (phase == 0) begin
      write_reg(CfgFrameWidth, CfgDataW'(MaxDim));
      write_reg(CfgFrameHeight, CfgDataW'(MaxDim));
      write_reg(CfgLineStride, CfgDataW'(MaxDim));
      write_reg(CfgChromaStep, 4);
      write_reg(CfgPatternOffs, 24'hFFFF);
      write_reg(CfgFixedColor, 0);
    end else if (phase == 1) begin
      write_reg(CfgFrameWidth, 2);
      write_reg(CfgFrameHeight, 2);
      write_reg(CfgLineStride, 2);
      write_reg(CfgChromaStep, 1);
      write_reg(CfgPatternOffs, 0);
      write_reg(CfgFixedColor, 0);
    end else begin
      write_reg(CfgFrameWidth, pick_dim());
      write_reg(CfgFrameHeight, pick_dim());
      write_reg(CfgLineStride, pick_dim());
      v = CfgDataW'($urandom);
      write_reg(CfgChromaStep, v);
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = 24'hFFFF;
        default: v = CfgDataW'($urandom);
      endcase
      write_reg(CfgPatternOffs, v);
      v = ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom) : '0;
      write_reg(CfgFixedColor, v);
    end
  endtask

  initial begin : stim
    blk_res_t r;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    block_x_i  = '0;
    block_y_i  = '0;
    reg_width  = DimRst;
    reg_height = DimRst;
    reg_stride = DimRst;
    reg_step   = ChromaStepRst;
    reg_offset = '0;
    reg_fixed  = '0;

    r = '{luma_value: 8'd0, cb_value: 8'd128, cr_value: 8'd128,
          luma_offset: '0, chroma_offset: '0, last_block: 1'b0};
    add_typed(0, 0, r);
    add_item(4094, 4094);
    add_item(4095, 4095);
    add_item(1022, 1022);
    add_item(1020, 1022);
    add_item(1, 3);
    add_item(64, 0);
    add_item(12'hAAA, 12'h555);
    add_item(12'h555, 12'hAAA);
    add_cfg(CfgFixedColor, 24'hFFFFFF);
    r.luma_value = 8'd255;
    add_typed(0, 0, r);
    add_cfg(CfgFixedColor, 24'h0000FF);
    add_item(2, 2);
    add_cfg(CfgFixedColor, 24'hFF0000);
    add_item(4, 4);
    add_cfg(CfgFixedColor, 24'hFFFF00);
    add_item(6, 6);
    add_cfg(CfgFixedColor, 24'h000000);
    add_cfg(CfgFrameWidth, 0);
    add_item(100, 200);
    add_cfg(CfgFrameWidth, 1);
    add_item(0, 0);
    add_cfg(CfgFrameWidth, 24'hFFFFFF);
    add_cfg(CfgFrameHeight, 8191);
    add_cfg(CfgLineStride, 8191);
    add_item(4094, 4094);
    add_cfg(CfgChromaStep, 7);
    add_cfg(CfgPatternOffs, 24'hFFFF);
    add_item(4094, 4094);
    add_item(4095, 0);
    add_cfg(CfgChromaStep, 0);
    add_item(10, 10);
    add_cfg(CfgUnused, 24'hFFFFFF);
    add_item(12, 12);
    add_cfg(CfgFrameWidth, 2);
    add_cfg(CfgFrameHeight, 2);
    add_cfg(CfgLineStride, 2);
    add_cfg(CfgChromaStep, 1);
    add_cfg(CfgPatternOffs, 0);
    add_item(0, 0);
    add_item(2, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        if (dir_rows[i].typed) begin
          typed_res   = dir_rows[i].res;
          typed_armed = 1'b1;
        end
        send_block(dir_rows[i].x, dir_rows[i].y);
      end
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain_results();
      config_phase(p);
      tx_idle_en = (p < 8) && (p != 3) && (p != 5);
      rx_idle_en = (p < 8) && (p != 5);
      if (p == 3) begin
        long_hold_req = 1'b1;
      end
      for (int unsigned k = 0; k < PhaseLen; k++) begin
        send_block(rand_coord(reg_width), rand_coord(reg_height));
      end
    end

    drain_results();
    repeat (EndWait) @(posedge clk_i);
    if (nv12_block_q.size() != 0) begin
      $error("%0d expected results never arrived", nv12_block_q.size());
      err_cnt++;
    end
    $display("Run covered %0d block transfers in, %0d out (%0d last blocks), %0d register writes,",
             n_in, n_out, n_last, n_cfg);
    $display("  with zero, minimum, maximum and oversized frame settings and fixed colors.");
    if (err_cnt == 0) begin
      $display("tb_nv12_test_pattern_block_top: PASS");
    end else begin
      $display("tb_nv12_test_pattern_block_top: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/nv12tp_pkg.sv
hw/rtl/nv12_test_pattern_block_top.sv
hw/rtl/nv12tp_checker.sv
dv/tb_nv12_test_pattern_block_top.sv
